// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file pfa_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AST_IMPL(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define AST_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/pfa_pkg.sv =====
// types and constants of the page frame allocator
package pfa_pkg;

	// opcodes of an input transaction
	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_ALLOC = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD     = 2'd1;
	localparam logic [1:0] ST_DOUBLE  = 2'd2;
	localparam logic [1:0] ST_NO_PAGE = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 1'b1;

	// configuration reset values
	localparam logic [31:0] RANGE_START_RST = 32'h8000_0000;
	localparam logic [31:0] RANGE_END_RST   = 32'h8800_0000;

	// stream widths
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 72;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_FILL,
		S_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic ready;
		logic take;
		logic sweep;
		logic commit;
	} pfa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_init;
		logic sweep_done;
		logic out_free;
	} pfa_stat_t;

endpackage

// ===== sv/pfa_ctrl.sv =====
// controller state machine of the page frame allocator
module pfa_ctrl
	import pfa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  pfa_stat_t stat,
	output pfa_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.sweep_done) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_nxt = stat.is_init ? S_FILL : S_EXEC;
			end
			S_FILL: begin
				if (stat.sweep_done) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (stat.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep = 1'b1;
			end
			S_IDLE: begin
				cmd.ready = 1'b1;
				cmd.take  = in_valid;
			end
			S_FILL: begin
				cmd.sweep = 1'b1;
			end
			S_EXEC: begin
				cmd.commit = stat.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== sv/pfa_datapath.sv =====
// datapath: config registers, free stack, free bitmap, counters, result register
module pfa_datapath
	import pfa_pkg::*;
#(
	parameter int unsigned NUM_PAGES  = 32768,
	parameter int unsigned PAGE_BYTES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfa_cmd_t             cmd,
	output pfa_stat_t            stat,
	input  logic [1:0]           opcode,
	input  logic [31:0]          page_addr,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [31:0]          cfg_wdata,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [1:0]           status,
	output logic [31:0]          granted_addr,
	output logic [15:0]          pages_free,
	output logic [15:0]          pages_taken
);

	localparam int unsigned SHIFT = $clog2(PAGE_BYTES);
	localparam int unsigned PG_W  = 32 - SHIFT;
	localparam int unsigned BP_W  = PG_W + 1;
	localparam int unsigned IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_PAGES + 1);
	localparam logic [BP_W-1:0] BASE_RST =
		BP_W'((33'(RANGE_START_RST) + 33'(PAGE_BYTES - 1)) >> SHIFT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_PAGES);

	// configuration and latched page base
	logic [31:0]      start_q;
	logic [31:0]      end_q;
	logic [BP_W-1:0]  base_page_q;

	// stack depth equals the free count
	logic [CNT_W-1:0] depth_q;
	logic [CNT_W-1:0] taken_q;
	logic [CNT_W-1:0] fill_n_q;
	logic [IDX_W-1:0] ptr_q;

	// per-item registers
	logic [1:0]       op_q;
	logic             bad_q;
	logic             empty_q;
	logic             full_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] stack_rd_q;
	logic             map_rd_q;

	// result register
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [31:0]      granted_q;
	logic [15:0]      free_out_q;
	logic [15:0]      taken_out_q;

	logic [IDX_W-1:0] stack_mem [NUM_PAGES];
	logic             map_mem   [NUM_PAGES];

	// take-time checks
	logic             aligned;
	logic [BP_W-1:0]  addr_page;
	logic [BP_W-1:0]  diff;
	logic [32:0]      diff_ext;
	logic             in_pages;
	logic             free_bad;
	logic [IDX_W-1:0] free_idx;
	logic [BP_W-1:0]  base_new;
	logic [BP_W-1:0]  end_page;
	logic [BP_W-1:0]  avail;
	logic [CNT_W-1:0] fill_n;
	logic [CNT_W-1:0] depth_dec;
	logic [IDX_W-1:0] pop_addr;

	// commit-time logic
	logic             push;
	logic             pop;
	logic [CNT_W-1:0] depth_nxt;
	logic [CNT_W-1:0] taken_nxt;
	logic [1:0]       status_nxt;
	logic [32:0]      grant_sum;
	logic [31:0]      granted_nxt;
	logic [31:0]      free_wide;
	logic [31:0]      taken_wide;
	logic             fill_hit;

	// memory write port selection
	logic             map_we;
	logic [IDX_W-1:0] map_wa;
	logic             map_wd;
	logic             stack_we;
	logic [IDX_W-1:0] stack_wa;
	logic [IDX_W-1:0] stack_wd;

	assign aligned   = (page_addr[SHIFT-1:0] == '0);
	assign addr_page = {1'b0, page_addr[31:SHIFT]};
	assign diff      = addr_page - base_page_q;
	assign diff_ext  = 33'(diff);
	assign in_pages  = (diff_ext < 33'(NUM_PAGES));
	assign free_idx  = diff_ext[IDX_W-1:0];
	assign free_bad  = !aligned || (page_addr < start_q) || (page_addr >= end_q) ||
		(addr_page < base_page_q) || !in_pages;

	assign base_new = {1'b0, start_q[31:SHIFT]} + BP_W'(start_q[SHIFT-1:0] != '0);
	assign end_page = {1'b0, end_q[31:SHIFT]};
	assign avail    = (end_page > base_new) ? (end_page - base_new) : '0;
	assign fill_n   = (33'(avail) >= 33'(NUM_PAGES)) ? FULL_CNT : CNT_W'(avail);

	assign depth_dec = depth_q - 1'b1;
	assign pop_addr  = depth_dec[IDX_W-1:0];
	assign fill_hit  = (CNT_W'(ptr_q) < fill_n_q);

	assign push = (op_q == OP_FREE) && !bad_q && !map_rd_q && !full_q;
	assign pop  = (op_q == OP_ALLOC) && !empty_q;

	always_comb begin
		depth_nxt = depth_q;
		taken_nxt = taken_q;
		if (push) begin
			depth_nxt = depth_q + 1'b1;
			if (taken_q != '0) taken_nxt = taken_q - 1'b1;
		end else if (pop) begin
			depth_nxt = depth_dec;
			taken_nxt = taken_q + 1'b1;
		end
	end

	always_comb begin
		case (op_q)
			OP_INIT:  status_nxt = ST_OK;
			OP_FREE:  status_nxt = bad_q ? ST_BAD :
				((map_rd_q || full_q) ? ST_DOUBLE : ST_OK);
			OP_ALLOC: status_nxt = empty_q ? ST_NO_PAGE : ST_OK;
			default:  status_nxt = ST_BAD;
		endcase
	end

	assign grant_sum   = 33'(base_page_q) + 33'(stack_rd_q);
	assign granted_nxt = pop ? {grant_sum[PG_W-1:0], {SHIFT{1'b0}}} : '0;
	assign free_wide   = 32'(depth_nxt);
	assign taken_wide  = 32'(taken_nxt);

	always_comb begin
		map_we   = 1'b0;
		map_wa   = ptr_q;
		map_wd   = fill_hit;
		stack_we = 1'b0;
		stack_wa = ptr_q;
		stack_wd = ptr_q;
		if (cmd.sweep) begin
			map_we   = 1'b1;
			stack_we = 1'b1;
		end else if (cmd.commit && push) begin
			map_we   = 1'b1;
			map_wa   = idx_q;
			map_wd   = 1'b1;
			stack_we = 1'b1;
			stack_wa = depth_q[IDX_W-1:0];
			stack_wd = idx_q;
		end else if (cmd.commit && pop) begin
			map_we = 1'b1;
			map_wa = stack_rd_q;
			map_wd = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		if (cmd.take) map_rd_q <= map_mem[free_idx];
	end

	always_ff @(posedge clk) begin
		if (stack_we) stack_mem[stack_wa] <= stack_wd;
		if (cmd.take) stack_rd_q <= stack_mem[pop_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= RANGE_START_RST;
			end_q   <= RANGE_END_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_RANGE_START: start_q <= cfg_wdata;
				CFG_RANGE_END:   end_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sweep pointer wraps to zero so the next init starts from the bottom
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.sweep) begin
			ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_page_q <= BASE_RST;
			fill_n_q    <= '0;
			depth_q     <= '0;
			taken_q     <= '0;
		end else if (cmd.take && (opcode == OP_INIT)) begin
			base_page_q <= base_new;
			fill_n_q    <= fill_n;
			depth_q     <= fill_n;
			taken_q     <= '0;
		end else if (cmd.commit) begin
			depth_q <= depth_nxt;
			taken_q <= taken_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= opcode;
			bad_q   <= free_bad;
			idx_q   <= free_idx;
			empty_q <= (depth_q == '0);
			full_q  <= (depth_q == FULL_CNT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q    <= status_nxt;
			granted_q   <= granted_nxt;
			free_out_q  <= free_wide[15:0];
			taken_out_q <= taken_wide[15:0];
		end
	end

	assign stat.is_init    = (opcode == OP_INIT);
	assign stat.sweep_done = (ptr_q == LAST_IDX);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_addr = granted_q;
	assign pages_free   = free_out_q;
	assign pages_taken  = taken_out_q;

endmodule

// ===== sv/page_frame_allocator.sv =====
// top level of the page frame allocator
//
// input stream carries one command per transaction: init range, free page or
// allocate page. every command gives exactly one result transaction on the
// output stream with a status, the granted page address and both page counters.
// the user must see that range_start_addr and range_end_addr are written through
// the cfg port only while the block is idle; the block does not enforce it. init
// latches the page-rounded start as the page base. free and allocate: the accept
// cycle reads the free stack and the free bitmap; the exec state updates them
// and loads the result when the output is free. init sweeps every bitmap entry
// and stack slot, one per cycle, since each memory has a single write port.
// after reset the same sweep clears the bitmap: tready stays low during it
// while cfg writes are still taken.
// the result sits in an output register; while the receiver stalls a new
// command is still accepted, and it waits in its final cycle until the
// register is free.
module page_frame_allocator
	import pfa_pkg::*;
#(
	parameter int unsigned NUM_PAGES  = 32768,
	parameter int unsigned PAGE_BYTES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// opcode[1:0], page_addr[33:2], zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status[1:0], granted_addr[33:2], pages_free[49:34], pages_taken[65:50], zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [31:0]           cfg_wdata
);

	pfa_cmd_t    cmd;
	pfa_stat_t   stat;
	logic [1:0]  status;
	logic [31:0] granted_addr;
	logic [15:0] pages_free;
	logic [15:0] pages_taken;

	pfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.stat     (stat),
		.cmd      (cmd)
	);

	pfa_datapath #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (s_axis_tdata[1:0]),
		.page_addr    (s_axis_tdata[33:2]),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.status       (status),
		.granted_addr (granted_addr),
		.pages_free   (pages_free),
		.pages_taken  (pages_taken)
	);

	assign s_axis_tready = cmd.ready;
	assign m_axis_tdata  = {6'b0, pages_taken, pages_free, granted_addr, status};

endmodule

// ===== sv/pfa_checker.sv =====
// port-level assertions of the page frame allocator and their bind
`include "assert_macros.svh"

module pfa_checker
	import pfa_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// a command is never taken in the cycle right after another one
	`AST_NEXT(a_take_gap, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// stalled result holds
	`AST_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// only a successful command may grant an address
	`AST_IMPL(a_grant_ok, clk, arst_n, m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK),
		m_axis_tdata[33:2] == 32'd0)

	// empty status means the free count is zero
	`AST_IMPL(a_empty_cnt, clk, arst_n, m_axis_tvalid && (m_axis_tdata[1:0] == ST_NO_PAGE),
		m_axis_tdata[49:34] == 16'd0)

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_page_frame_allocator.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the page frame allocator: directed and random command streams
module tb_page_frame_allocator;
	import pfa_pkg::*;

	localparam int unsigned     NUM_PAGES     = 32768;
	localparam int unsigned     PAGE_BYTES    = 4096;
	localparam int unsigned     SLOT_W        = $clog2(NUM_PAGES);
	localparam logic [1:0]      OP_UNUSED     = 2'd3;
	localparam int unsigned     SETTLE_CYCLES = 8;
	localparam int unsigned     MAX_REPORTS   = 10;
	localparam int unsigned     POOL_DEPTH    = 64;
	localparam longint unsigned CYCLE_LIMIT   = 2_000_000;

	// lowest field last so the struct lines up with m_axis_tdata
	typedef struct packed {
		logic [15:0] pages_taken;
		logic [15:0] pages_free;
		logic [31:0] granted_addr;
		logic [1:0]  status;
	} alloc_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// opcode[1:0], page_addr[33:2], zero fill
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// status[1:0], granted_addr[33:2], pages_free[49:34], pages_taken[65:50], zero fill
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [31:0]           cfg_wdata;

	page_frame_allocator #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// allocator state as the block should hold it
	logic [SLOT_W-1:0] frame_stack [NUM_PAGES];
	bit                frame_map   [NUM_PAGES];
	int unsigned       stack_top;
	int unsigned       free_cnt;
	int unsigned       taken_cnt;
	longint unsigned   page_base;
	logic [31:0]       range_lo = RANGE_START_RST;
	logic [31:0]       range_hi = RANGE_END_RST;
	alloc_result_t     outcome_q [$];
	logic [31:0]       granted_pool [$];

	int unsigned       mismatches = 0;
	int unsigned       send_idle_pct;
	int unsigned       recv_stall_pct;
	int unsigned       hold_cycles;
	longint unsigned   cycles = 0;

	function automatic longint unsigned round_to_page(input logic [31:0] a);
		longint unsigned wide;
		longint unsigned rem;
		wide = a;
		rem = wide % PAGE_BYTES;
		return (rem != 0) ? wide + PAGE_BYTES - rem : wide;
	endfunction

	// applies one command to the allocator state and queues the result it gives
	task automatic allocator_step(input logic [1:0] op, input logic [31:0] addr);
		alloc_result_t   res;
		longint unsigned p;
		longint unsigned slot;
		res = '0;
		case (op)
			OP_INIT: begin
				for (int i = 0; i < NUM_PAGES; i++)
					frame_map[i] = 1'b0;
				stack_top = 0;
				free_cnt = 0;
				taken_cnt = 0;
				page_base = round_to_page(range_lo);
				p = page_base;
				while (stack_top < NUM_PAGES && p + PAGE_BYTES <= range_hi) begin
					frame_stack[stack_top] = stack_top[SLOT_W-1:0];
					frame_map[stack_top] = 1'b1;
					stack_top++;
					free_cnt++;
					p += PAGE_BYTES;
				end
			end
			OP_FREE: begin
				if (addr % PAGE_BYTES != 0 || addr < range_lo || addr >= range_hi ||
						addr < page_base)
					res.status = ST_BAD;
				else begin
					slot = (addr - page_base) / PAGE_BYTES;
					if (slot >= NUM_PAGES)
						res.status = ST_BAD;
					else if (frame_map[slot] || stack_top >= NUM_PAGES)
						res.status = ST_DOUBLE;
					else begin
						frame_stack[stack_top] = slot[SLOT_W-1:0];
						stack_top++;
						frame_map[slot] = 1'b1;
						free_cnt++;
						if (taken_cnt > 0)
							taken_cnt--;
					end
				end
			end
			OP_ALLOC: begin
				if (stack_top == 0)
					res.status = ST_NO_PAGE;
				else begin
					stack_top--;
					slot = frame_stack[stack_top];
					frame_map[slot] = 1'b0;
					if (free_cnt > 0)
						free_cnt--;
					taken_cnt++;
					res.granted_addr = 32'(page_base + slot * PAGE_BYTES);
					granted_pool.push_back(res.granted_addr);
					if (granted_pool.size() > POOL_DEPTH)
						void'(granted_pool.pop_front());
				end
			end
			default: begin
				res.status = ST_BAD;
			end
		endcase
		res.pages_free = 16'(free_cnt);
		res.pages_taken = 16'(taken_cnt);
		outcome_q.push_back(res);
	endtask

	function automatic void note_mismatch(input string what, input alloc_result_t want,
			input alloc_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: exp status %0d addr %h free %0d taken %0d, act status %0d addr %h free %0d taken %0d",
				$realtime, what, want.status, want.granted_addr, want.pages_free,
				want.pages_taken, got.status, got.granted_addr, got.pages_free,
				got.pages_taken);
	endfunction

	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = alloc_result_t'(m_axis_tdata[$bits(alloc_result_t)-1:0]);
			if (outcome_q.size() == 0)
				note_mismatch("result with none pending", '0, got);
			else begin
				want = outcome_q.pop_front();
				if (got.status !== want.status || got.granted_addr !== want.granted_addr ||
						got.pages_free !== want.pages_free ||
						got.pages_taken !== want.pages_taken)
					note_mismatch("result differs", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_page_frame_allocator failed");
			$finish;
		end
	end

	// result side: long hold-off first when one is requested, else random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready = 1'b0;
			hold_cycles--;
		end else
			m_axis_tready = ($urandom_range(99, 0) >= recv_stall_pct);
	end

	task automatic send_cmd(input logic [1:0] op, input logic [31:0] addr);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {{(IN_DATA_W-34){1'b0}}, addr, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		allocator_step(op, addr);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_RANGE_START)
			range_lo = val;
		else
			range_hi = val;
	endtask

	task automatic wait_drained();
		while (outcome_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly pages handed out earlier or pages of the window, some bad addresses
	function automatic logic [31:0] pick_free_addr(input int unsigned win_pages);
		int unsigned     k;
		longint unsigned slot;
		k = $urandom_range(99, 0);
		if (k < 45 && granted_pool.size() != 0)
			return granted_pool[$urandom_range(granted_pool.size() - 1, 0)];
		slot = $urandom_range(win_pages + 1, 0);
		if (k < 75)
			return 32'(page_base + slot * PAGE_BYTES);
		if (k < 82)
			return 32'(page_base - PAGE_BYTES);
		if (k < 92)
			return 32'(page_base + slot * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1, 1));
		return $urandom();
	endfunction

	task automatic test_before_init();
		send_cmd(OP_ALLOC, 32'h0);
		// pages may be freed before any init; the taken count does not drop below zero
		send_cmd(OP_FREE, RANGE_START_RST);
		send_cmd(OP_FREE, RANGE_START_RST);
		send_cmd(OP_FREE, RANGE_START_RST + PAGE_BYTES);
		send_cmd(OP_ALLOC, 32'hFFFF_FFFF);
		send_cmd(OP_FREE, RANGE_START_RST + PAGE_BYTES);
		send_cmd(OP_UNUSED, 32'hFFFF_FFFF);
	endtask

	task automatic test_small_range();
		wait_drained();
		// unaligned start rounds up, four pages in all
		write_cfg(CFG_RANGE_START, 32'h0000_1001);
		write_cfg(CFG_RANGE_END, 32'h0000_6000);
		send_cmd(OP_INIT, 32'hFFFF_FFFF);
		send_cmd(OP_FREE, 32'h0000_2001);
		send_cmd(OP_FREE, 32'h0000_1000);
		send_cmd(OP_FREE, 32'h0000_6000);
		send_cmd(OP_FREE, 32'h0000_2000);
		repeat (5) send_cmd(OP_ALLOC, 32'h0);
		send_cmd(OP_FREE, 32'h0000_3000);
		send_cmd(OP_ALLOC, 32'h0);
	endtask

	task automatic test_range_extremes();
		wait_drained();
		write_cfg(CFG_RANGE_START, 32'h0);
		write_cfg(CFG_RANGE_END, 32'hFFFF_FFFF);
		send_cmd(OP_INIT, 32'h0);
		// first page past the page limit
		send_cmd(OP_FREE, 32'h0800_0000);
		send_cmd(OP_ALLOC, 32'h0);
		send_cmd(OP_FREE, 32'h07FF_F000);
		send_cmd(OP_FREE, 32'h0);
		wait_drained();
		// base rounds past the top of the address space, nothing gets pushed
		write_cfg(CFG_RANGE_START, 32'hFFFF_F001);
		send_cmd(OP_INIT, 32'h0);
		send_cmd(OP_FREE, 32'hFFFF_F000);
		send_cmd(OP_ALLOC, 32'h0);
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input logic [31:0] lo, input logic [31:0] hi, input int unsigned n_items,
			input bit reinit, input int unsigned hold);
		int unsigned win_pages;
		int unsigned alloc_pct;
		int unsigned r;
		wait_drained();
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_cfg(CFG_RANGE_START, lo);
		write_cfg(CFG_RANGE_END, hi);
		send_cmd(OP_INIT, $urandom());
		wait_drained();
		win_pages = free_cnt;
		hold_cycles = hold;
		alloc_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			// shift the mix now and then so the list both empties and refills
			if (i % 64 == 0)
				alloc_pct = 30 + 20 * $urandom_range(2, 0);
			r = $urandom_range(99, 0);
			if (reinit && i == n_items / 2)
				send_cmd(OP_INIT, $urandom());
			else if (r < 3)
				send_cmd(OP_UNUSED, $urandom());
			else if (r < 3 + alloc_pct)
				send_cmd(OP_ALLOC, $urandom());
			else
				send_cmd(OP_FREE, pick_free_addr(win_pages));
		end
	endtask

	initial begin
		logic [31:0] lo;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		stack_top = 0;
		free_cnt = 0;
		taken_cnt = 0;
		page_base = round_to_page(RANGE_START_RST);
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_before_init();
		test_small_range();
		test_range_extremes();
		test_random_traffic(0, 0, 32'h0, 32'h0001_0000, 380, 1'b0, 0);
		test_random_traffic(50, 0, 32'hFFFE_F123, 32'hFFFF_FFFF, 380, 1'b1, 0);
		lo = $urandom_range(32'hE000_0000, 0);
		test_random_traffic(0, 50, lo,
			lo + $urandom_range(48, 8) * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1, 0),
			380, 1'b0, 300);
		lo = $urandom_range(32'hE000_0000, 0);
		test_random_traffic(33, 33, lo,
			lo + $urandom_range(96, 16) * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1, 0),
			380, 1'b1, 0);
		wait_drained();

		if (mismatches == 0 && outcome_q.size() == 0)
			$display("tb_page_frame_allocator passed");
		else
			$display("tb_page_frame_allocator failed");
		$finish;
	end

endmodule
